// ===== sv/cbsr_pkg.sv =====
// Shared types and constants for the clock buffer slot replacer.
package cbsr_pkg;

  localparam int SLOTS_DEF = 64;
  localparam int KIND_W    = 3;
  localparam int SLOT_W    = 6;
  localparam int GRP_W     = 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC   = 3'd0,
    KIND_PIN     = 3'd1,
    KIND_UNPIN   = 3'd2,
    KIND_DIRTY   = 3'd3,
    KIND_RELEASE = 3'd4
  } kind_t;

  typedef struct packed {
    logic load_req;
    logic exec_simple;
    logic scan_start;
    logic scan_step;
    logic sweep_start;
    logic sweep_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_alloc;
    logic full;
    logic scan_hit;
    logic sweep_hit;
    logic sweep_last;
  } sts_t;

endpackage

// ===== sv/cbsr_datapath.sv =====
// Slot state bits, clock hand, free-slot scan, victim sweep and result registers.
module cbsr_datapath #(
  parameter int SLOTS = cbsr_pkg::SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cbsr_pkg::cmd_t                cmd,
  output cbsr_pkg::sts_t                sts,
  input  logic [cbsr_pkg::KIND_W-1:0]   in_kind,
  input  logic [cbsr_pkg::SLOT_W-1:0]   in_slot,
  output logic [cbsr_pkg::SLOT_W-1:0]   out_granted_slot,
  output logic                          out_evicted,
  output logic                          out_write_back,
  output logic                          out_no_victim
);

  localparam int SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW     = $clog2(SLOTS + 1);
  localparam int NW     = $clog2(2 * SLOTS);
  localparam int GROUPS = (SLOTS + cbsr_pkg::GRP_W - 1) / cbsr_pkg::GRP_W;
  localparam int GIW    = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int PADW   = (1 << GIW) * cbsr_pkg::GRP_W;
  localparam int PW     = $clog2(cbsr_pkg::GRP_W);

  logic [SLOTS-1:0]            valid_r;
  logic [SLOTS-1:0]            ref_r;
  logic [SLOTS-1:0]            pin_r;
  logic [SLOTS-1:0]            dirty_r;
  logic [SW-1:0]               hand_r;
  logic [CW-1:0]               cnt_r;
  logic [cbsr_pkg::KIND_W-1:0] req_kind_r;
  logic [cbsr_pkg::SLOT_W-1:0] req_slot_r;
  logic [GIW-1:0]              grp_r;
  logic [SW-1:0]               idx_r;
  logic [NW-1:0]               n_r;
  logic [cbsr_pkg::SLOT_W-1:0] res_granted_r;
  logic                        res_evicted_r;
  logic                        res_wb_r;
  logic                        res_none_r;
  logic [cbsr_pkg::SLOT_W-1:0] out_granted_r;
  logic                        out_evicted_r;
  logic                        out_wb_r;
  logic                        out_none_r;

  logic [PADW-1:0]              free_pad;
  logic [cbsr_pkg::GRP_W-1:0]   grp_free;
  logic [PW-1:0]                grp_pos;
  logic                         scan_hit;
  logic [SW-1:0]                scan_idx;
  logic                         in_range;
  logic [SW-1:0]                slot_idx;
  logic [SW-1:0]                idx_next;
  logic                         sweep_hit;
  logic                         sweep_last;

  assign free_pad = PADW'(~valid_r);
  assign grp_free = free_pad[grp_r * cbsr_pkg::GRP_W +: cbsr_pkg::GRP_W];
  assign scan_hit = |grp_free;

  always_comb begin
    grp_pos = '0;
    for (int k = cbsr_pkg::GRP_W - 1; k >= 0; k--) begin
      if (grp_free[k]) begin
        grp_pos = PW'(k);
      end
    end
  end

  assign scan_idx   = SW'({grp_r, grp_pos});
  assign in_range   = 32'(req_slot_r) < 32'(SLOTS);
  assign slot_idx   = SW'(req_slot_r);
  assign idx_next   = (idx_r == SW'(SLOTS - 1)) ? '0 : idx_r + SW'(1);
  assign sweep_hit  = !ref_r[idx_r] && !pin_r[idx_r];
  assign sweep_last = n_r == NW'(2 * SLOTS - 1);

  assign sts.is_alloc   = req_kind_r == cbsr_pkg::KIND_ALLOC;
  assign sts.full       = cnt_r == CW'(SLOTS);
  assign sts.scan_hit   = scan_hit;
  assign sts.sweep_hit  = sweep_hit;
  assign sts.sweep_last = sweep_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      ref_r   <= '0;
      pin_r   <= '0;
      dirty_r <= '0;
      hand_r  <= SW'(SLOTS - 1);
      cnt_r   <= '0;
    end else begin
      if (cmd.exec_simple && in_range) begin
        case (cbsr_pkg::kind_t'(req_kind_r))
          cbsr_pkg::KIND_PIN: begin
            if (valid_r[slot_idx]) pin_r[slot_idx] <= 1'b1;
          end
          cbsr_pkg::KIND_UNPIN: begin
            if (valid_r[slot_idx]) pin_r[slot_idx] <= 1'b0;
          end
          cbsr_pkg::KIND_DIRTY: begin
            if (valid_r[slot_idx]) dirty_r[slot_idx] <= 1'b1;
          end
          cbsr_pkg::KIND_RELEASE: begin
            valid_r[slot_idx] <= 1'b0;
            ref_r[slot_idx]   <= 1'b0;
            pin_r[slot_idx]   <= 1'b0;
            dirty_r[slot_idx] <= 1'b0;
            if (valid_r[slot_idx]) cnt_r <= cnt_r - CW'(1);
          end
          default: begin
          end
        endcase
      end
      if (cmd.scan_step && scan_hit) begin
        valid_r[scan_idx] <= 1'b1;
        ref_r[scan_idx]   <= 1'b1;
        pin_r[scan_idx]   <= 1'b0;
        dirty_r[scan_idx] <= 1'b0;
        cnt_r             <= cnt_r + CW'(1);
      end
      if (cmd.sweep_step) begin
        if (sweep_hit) begin
          hand_r         <= idx_r;
          ref_r[idx_r]   <= 1'b1;
          pin_r[idx_r]   <= 1'b0;
          dirty_r[idx_r] <= 1'b0;
        end else begin
          ref_r[idx_r] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_kind_r <= in_kind;
      req_slot_r <= in_slot;
    end
    if (cmd.exec_simple) begin
      res_granted_r <= req_slot_r;
      res_evicted_r <= 1'b0;
      res_wb_r      <= 1'b0;
      res_none_r    <= 1'b0;
    end
    if (cmd.scan_start) begin
      grp_r <= '0;
    end
    if (cmd.scan_step) begin
      grp_r         <= grp_r + GIW'(1);
      res_granted_r <= cbsr_pkg::SLOT_W'(scan_idx);
      res_evicted_r <= 1'b0;
      res_wb_r      <= 1'b0;
      res_none_r    <= 1'b0;
    end
    if (cmd.sweep_start) begin
      idx_r <= (hand_r == SW'(SLOTS - 1)) ? '0 : hand_r + SW'(1);
      n_r   <= '0;
    end
    if (cmd.sweep_step) begin
      idx_r         <= idx_next;
      n_r           <= n_r + NW'(1);
      res_granted_r <= sweep_hit ? cbsr_pkg::SLOT_W'(idx_r) : '0;
      res_evicted_r <= sweep_hit;
      res_wb_r      <= sweep_hit && dirty_r[idx_r];
      res_none_r    <= !sweep_hit;
    end
    if (cmd.out_load) begin
      out_granted_r <= res_granted_r;
      out_evicted_r <= res_evicted_r;
      out_wb_r      <= res_wb_r;
      out_none_r    <= res_none_r;
    end
  end

  assign out_granted_slot = out_granted_r;
  assign out_evicted      = out_evicted_r;
  assign out_write_back   = out_wb_r;
  assign out_no_victim    = out_none_r;

endmodule

// ===== sv/cbsr_ctrl.sv =====
// Request sequencer: decode, free-slot scan, victim sweep and result handoff.
module cbsr_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  output cbsr_pkg::cmd_t cmd,
  input  cbsr_pkg::sts_t sts
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_SWEEP,
    ST_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load_req = 1'b1;
          state_nxt    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (!sts.is_alloc) begin
          cmd.exec_simple = 1'b1;
          state_nxt       = ST_DONE;
        end else if (sts.full) begin
          cmd.sweep_start = 1'b1;
          state_nxt       = ST_SWEEP;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_hit) state_nxt = ST_DONE;
      end
      ST_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_hit || sts.sweep_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && !out_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = state_r == ST_IDLE;
  assign out_tvalid = out_valid_r;

endmodule

// ===== sv/clock_buffer_slot_replacer.sv =====
// Top level of the clock buffer slot replacer.
// Pin, unpin, mark dirty and release pass through decode and done before out_tvalid rises;
// allocate also scans groups of 8 slots for a free one, or sweeps positions (at most 2*SLOTS).
// Only one request is in work; a new transfer is accepted once the result loads and the
// sequencer is idle again, later while a held result waits on out_tready.
// Reset clears every slot bit, parks the hand on the last slot and empties the output.
module clock_buffer_slot_replacer #(
  parameter int SLOTS = cbsr_pkg::SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [5:0] slot
  input  logic [2:0]  in_tuser,   // [2:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [5:0] granted_slot, [6] evicted, [7] write_back,
                                  // [8] no_victim
);

  cbsr_pkg::cmd_t              cmd;
  cbsr_pkg::sts_t              sts;
  logic [cbsr_pkg::SLOT_W-1:0] granted_slot;
  logic                        evicted;
  logic                        write_back;
  logic                        no_victim;

  cbsr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  cbsr_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_kind          (in_tuser),
    .in_slot          (in_tdata[cbsr_pkg::SLOT_W-1:0]),
    .out_granted_slot (granted_slot),
    .out_evicted      (evicted),
    .out_write_back   (write_back),
    .out_no_victim    (no_victim)
  );

  assign out_tdata = {7'd0, no_victim, write_back, evicted, granted_slot};

endmodule
